// File: sv/lfpg_pkg.sv
// ----------------------------------------------------------------------------
// lfpg_pkg: shared types and constants for the light fade pattern generator
// Pattern codes, request kinds, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package lfpg_pkg;

  localparam int unsigned PAT_W     = 3;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned T_W       = 17;   // elapsed time, saturating
  localparam int unsigned PH_W      = 7;    // strobe phase, mod 77
  localparam int unsigned LVL_W     = 8;
  localparam int unsigned NUM_W     = 25;   // 255 * t
  localparam int unsigned DS_W      = 23;   // divisor << 7
  localparam int unsigned IN_DATA_W = 24;   // pattern + duration, byte padded

  localparam logic [LVL_W-1:0] FULL          = 8'd255;
  localparam logic [PH_W-1:0]  STROBE_LAST   = 7'd76;   // period 77
  localparam logic [PH_W-1:0]  STROBE_ON     = 7'd38;
  localparam logic [T_W-1:0]   ELAPSED_MAX   = 17'h1FFFF;

  // request kind carried in tuser
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [PAT_W-1:0] PAT_OFF     = 3'd0;
  localparam logic [PAT_W-1:0] PAT_ON      = 3'd1;
  localparam logic [PAT_W-1:0] PAT_RAMP_UP = 3'd2;
  localparam logic [PAT_W-1:0] PAT_RAMP_DN = 3'd3;
  localparam logic [PAT_W-1:0] PAT_UP_DN   = 3'd4;
  localparam logic [PAT_W-1:0] PAT_DN_UP   = 3'd5;
  localparam logic [PAT_W-1:0] PAT_STROBE  = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_DIV   = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

endpackage

// File: sv/light_fade_pattern_generator.sv
// ----------------------------------------------------------------------------
// light_fade_pattern_generator: timed brightness patterns for one PWM channel
// Start beats load a pattern and a duration; tick beats give at most one level each.
// ----------------------------------------------------------------------------
// Flow: a tick passes setup, then the divider steps if it needs a quotient, and
//   then the output state; a tick that gives no level goes from setup back to idle.
// One beat at a time: a start beat is taken in idle and leaves it idle, and a new
//   beat is taken only after the last tick's level is taken. The 8-step shared
//   restoring divider does one 25-bit compare/subtract per cycle.
// Reset (rst, sync, active high): off pattern, zero duration and time, idle.
module light_fade_pattern_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lfpg_pkg::IN_DATA_W-1:0]   s_tdata,   // [2:0] pattern, [18:3] duration_ms
  input  logic                             s_tuser,   // [0] req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lfpg_pkg::LVL_W-1:0]       m_tdata    // [7:0] level
);

  lfpg_pkg::state_t state;

  // pattern state
  logic [lfpg_pkg::PAT_W-1:0] active_pattern;
  logic [lfpg_pkg::DUR_W-1:0] pattern_length;
  logic [lfpg_pkg::T_W-1:0]   elapsed_ms;
  logic [lfpg_pkg::PH_W-1:0]  strobe_phase;
  logic                       level_written;

  // divider registers
  logic [lfpg_pkg::NUM_W-1:0] rem;
  logic [lfpg_pkg::DS_W-1:0]  ds;
  logic [lfpg_pkg::LVL_W-1:0] quo;
  logic [2:0]                 step;
  logic                       inv;
  logic [lfpg_pkg::LVL_W-1:0] level;

  // setup decode
  logic                       su_skip;
  logic                       su_div;
  logic                       su_inv;
  logic [lfpg_pkg::LVL_W-1:0] su_base;
  logic [lfpg_pkg::NUM_W-1:0] su_num;
  logic [lfpg_pkg::DUR_W-1:0] su_dv;
  logic [14:0]                half;
  logic                       fall_half;
  logic [lfpg_pkg::T_W-1:0]   tx;
  logic [lfpg_pkg::NUM_W-1:0] num255;

  // shared compare/subtract
  logic [lfpg_pkg::NUM_W-1:0] ds_ext;
  logic [lfpg_pkg::NUM_W-1:0] diff;
  logic                       fits;
  logic [lfpg_pkg::LVL_W-1:0] quo_next;

  logic in_beat;
  logic out_beat;

  assign s_tready = (state == lfpg_pkg::S_IDLE);
  assign m_tvalid = (state == lfpg_pkg::S_OUT);
  assign m_tdata  = level;
  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  assign half   = pattern_length[lfpg_pkg::DUR_W-1:1];
  // triangle past its peak: time is measured from the start of the second half
  assign fall_half = (active_pattern inside {lfpg_pkg::PAT_UP_DN, lfpg_pkg::PAT_DN_UP}) &&
                     (elapsed_ms >= {2'b0, half});
  assign tx     = fall_half ? (elapsed_ms - {2'b0, half}) : elapsed_ms;
  assign num255 = {tx, 8'b0} - {8'b0, tx};

  always_comb begin
    su_skip = 1'b0;
    su_div  = 1'b0;
    su_inv  = 1'b0;
    su_base = '0;
    su_num  = num255;
    su_dv   = pattern_length;
    case (active_pattern)
      lfpg_pkg::PAT_RAMP_UP, lfpg_pkg::PAT_RAMP_DN: begin
        su_inv = (active_pattern == lfpg_pkg::PAT_RAMP_DN);
        // zero duration falls in here too: t >= 0
        if (elapsed_ms >= {1'b0, pattern_length}) begin
          su_base = lfpg_pkg::FULL;
        end else begin
          su_div = 1'b1;
        end
      end
      lfpg_pkg::PAT_UP_DN, lfpg_pkg::PAT_DN_UP: begin
        su_inv = (active_pattern == lfpg_pkg::PAT_DN_UP);
        su_dv  = {1'b0, half};
        // past the end, or a zero half: base level 0
        if (elapsed_ms >= {1'b0, half, 1'b0}) begin
          su_base = '0;
        end else if (elapsed_ms < {2'b0, half}) begin
          su_div = 1'b1;
        end else begin
          // second half: ceil(255*(t-H)/H), inverted to 255 minus that for up-down
          su_div = 1'b1;
          su_inv = (active_pattern != lfpg_pkg::PAT_DN_UP);
          su_num = num255 + {10'b0, half - 15'd1};
        end
      end
      lfpg_pkg::PAT_STROBE: begin
        if (elapsed_ms > {1'b0, pattern_length} || strobe_phase < lfpg_pkg::STROBE_ON) begin
          su_base = lfpg_pkg::FULL;
        end
      end
      default: begin
        // off, on and code seven: one level after a start
        su_skip = level_written;
        su_base = (active_pattern == lfpg_pkg::PAT_ON) ? lfpg_pkg::FULL : '0;
      end
    endcase
  end

  assign ds_ext   = {2'b0, ds};
  assign diff     = rem - ds_ext;
  assign fits     = (rem >= ds_ext);
  assign quo_next = {quo[lfpg_pkg::LVL_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= lfpg_pkg::S_IDLE;
      active_pattern <= lfpg_pkg::PAT_OFF;
      pattern_length <= '0;
      elapsed_ms     <= '0;
      strobe_phase   <= '0;
      level_written  <= 1'b0;
    end else begin
      case (state)
        lfpg_pkg::S_IDLE: begin
          if (in_beat) begin
            if (s_tuser == lfpg_pkg::REQ_START) begin
              active_pattern <= s_tdata[lfpg_pkg::PAT_W-1:0];
              pattern_length <= s_tdata[lfpg_pkg::PAT_W +: lfpg_pkg::DUR_W];
              elapsed_ms     <= '0;
              strobe_phase   <= '0;
              level_written  <= 1'b0;
            end else begin
              state <= lfpg_pkg::S_SETUP;
            end
          end
        end
        lfpg_pkg::S_SETUP: begin
          if (su_skip) begin
            state <= lfpg_pkg::S_IDLE;
          end else begin
            level_written <= 1'b1;
            if (elapsed_ms != lfpg_pkg::ELAPSED_MAX) begin
              elapsed_ms <= elapsed_ms + 17'd1;
            end
            strobe_phase <= (strobe_phase == lfpg_pkg::STROBE_LAST) ? '0
                                                                     : strobe_phase + 7'd1;
            state <= su_div ? lfpg_pkg::S_DIV : lfpg_pkg::S_OUT;
          end
        end
        lfpg_pkg::S_DIV: begin
          if (step == 3'd0) begin
            state <= lfpg_pkg::S_OUT;
          end
        end
        lfpg_pkg::S_OUT: begin
          if (out_beat) begin
            state <= lfpg_pkg::S_IDLE;
          end
        end
        default: begin
          state <= lfpg_pkg::S_IDLE;
        end
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      lfpg_pkg::S_SETUP: begin
        rem   <= su_num;
        ds    <= {su_dv, 7'b0};
        quo   <= '0;
        step  <= 3'd7;
        inv   <= su_inv;
        level <= su_base ^ {lfpg_pkg::LVL_W{su_inv}};
      end
      lfpg_pkg::S_DIV: begin
        if (fits) begin
          rem <= diff;
        end
        ds   <= ds >> 1;
        quo  <= quo_next;
        step <= step - 3'd1;
        if (step == 3'd0) begin
          level <= quo_next ^ {lfpg_pkg::LVL_W{inv}};
        end
      end
      default: begin
      end
    endcase
  end

  // a beat is never taken in while a level waits
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while output valid");

  // remainder stays below twice the shifted divisor, so 8 quotient bits suffice
  assert property (@(posedge clk) disable iff (rst)
    (state == lfpg_pkg::S_DIV) |-> (rem < {1'b0, ds, 1'b0}))
    else $error("divider remainder out of range");

  // start beats give no result and leave the block idle
  assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_tuser == lfpg_pkg::REQ_START) |=> s_tready)
    else $error("start beat did not return to idle");

  // once the level is taken the block is ready again
  assert property (@(posedge clk) disable iff (rst) out_beat |=> s_tready)
    else $error("not idle after output beat");

endmodule
